[hdl/shifting_array_list_table_unit_macros.svh]
// Assertion macros used by the list table datapath.
`ifndef SHIFTING_ARRAY_LIST_TABLE_UNIT_MACROS_SVH
`define SHIFTING_ARRAY_LIST_TABLE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge out of reset.
`define SAL_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Condition that must hold in the cycle after the trigger.
`define SAL_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);
`else
`define SAL_ASSERT_ALWAYS(lbl, expr, msg)
`define SAL_ASSERT_NEXT(lbl, trig, cons, msg)
`endif
`endif

[hdl/sal_pkg.sv]
// Shared constants, codes and controller/datapath interface types.
package sal_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DW    = 32;
  localparam int FW    = 3;
  localparam int PW    = 7;
  localparam int SW    = 2;

  localparam logic [FW-1:0] FN_APPEND = 3'd0;
  localparam logic [FW-1:0] FN_INSERT = 3'd1;
  localparam logic [FW-1:0] FN_GET    = 3'd2;
  localparam logic [FW-1:0] FN_DELETE = 3'd3;
  localparam logic [FW-1:0] FN_EDIT   = 3'd4;
  localparam logic [FW-1:0] FN_SEARCH = 3'd5;

  localparam logic [SW-1:0] ST_OK     = 2'd0;
  localparam logic [SW-1:0] ST_BADPOS = 2'd1;
  localparam logic [SW-1:0] ST_FULL   = 2'd2;

  typedef enum logic [1:0] {WA_FILL, WA_POS, WA_IDX} wa_sel_t;
  typedef enum logic [2:0] {RA_POS, RA_POS1, RA_FILLM1, RA_ZERO, RA_IDXP1, RA_IDXP2,
                            RA_IDXM2} ra_sel_t;
  typedef enum logic [2:0] {IX_HOLD, IX_POS, IX_FILL, IX_ZERO, IX_INC, IX_DEC} ix_op_t;

  typedef struct packed {
    logic    req_ld;
    logic    st_ld;
    logic    mem_we;
    wa_sel_t wa_sel;
    logic    wd_rdata;
    ra_sel_t ra_sel;
    ix_op_t  ix_op;
    logic    fill_inc;
    logic    fill_dec;
    logic    rd_cap;
    logic    hit_set;
    logic    out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic [FW-1:0] func;
    logic [SW-1:0] chk;
    logic          ins_at_end;
    logic          del_last;
    logic          dsh_last;
    logic          ish_last;
    logic          srch_end;
    logic          hit;
    logic          fill_zero;
    logic          out_free;
  } dp_stat_t;

endpackage

[hdl/sal_dp.sv]
// Datapath: entry memory, fill count, limit register, request and result registers.
module sal_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sal_pkg::dp_cmd_t          cmd,
  output sal_pkg::dp_stat_t         stat,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [sal_pkg::CW-1:0]    cfg_capacity_limit,
  input  logic [sal_pkg::FW-1:0]    in_func,
  input  logic [sal_pkg::PW-1:0]    in_position,
  input  logic signed [sal_pkg::DW-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [sal_pkg::SW-1:0]    out_status,
  output logic signed [sal_pkg::DW-1:0] out_read_value,
  output logic                      out_found,
  output logic [sal_pkg::AW-1:0]    out_found_position,
  output logic [sal_pkg::CW-1:0]    out_element_count
);
  import sal_pkg::*;

  `include "shifting_array_list_table_unit_macros.svh"

  logic [DW-1:0]        mem [DEPTH];
  logic [DW-1:0]        rdata_r;
  logic [CW-1:0]        fill_r, fill_nxt;
  logic [CW-1:0]        cap_r;
  logic [CW-1:0]        eff_cap;
  logic                 full;
  logic [FW-1:0]        func_r;
  logic [PW-1:0]        pos_r;
  logic signed [DW-1:0] val_r;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [SW-1:0]        chk;
  logic [SW-1:0]        status_r;
  logic signed [DW-1:0] rd_val_r;
  logic                 found_r;
  logic [AW-1:0]        fpos_r;
  logic                 out_valid_r;
  logic [AW-1:0]        wa;
  logic [DW-1:0]        wd;
  logic [AW-1:0]        ra;

  assign cfg_ready = 1'b1;

  // Limits above the store depth act as the depth.
  assign eff_cap = (cap_r > CW'(DEPTH)) ? CW'(DEPTH) : cap_r;
  assign full    = (fill_r >= eff_cap);

  always_comb begin
    chk = ST_OK;
    unique case (func_r)
      FN_APPEND: if (full) chk = ST_FULL;
      FN_INSERT: begin
        if (pos_r > fill_r) chk = ST_BADPOS;
        else if (full)      chk = ST_FULL;
      end
      FN_GET, FN_DELETE, FN_EDIT: if (pos_r >= fill_r) chk = ST_BADPOS;
      default: chk = ST_OK;
    endcase
  end

  always_comb begin
    unique case (cmd.wa_sel)
      WA_FILL: wa = fill_r[AW-1:0];
      WA_POS:  wa = pos_r[AW-1:0];
      WA_IDX:  wa = idx_r;
      default: wa = idx_r;
    endcase
    wd = cmd.wd_rdata ? rdata_r : val_r;
    unique case (cmd.ra_sel)
      RA_POS:    ra = pos_r[AW-1:0];
      RA_POS1:   ra = pos_r[AW-1:0] + AW'(1);
      RA_FILLM1: ra = fill_r[AW-1:0] - AW'(1);
      RA_ZERO:   ra = '0;
      RA_IDXP1:  ra = idx_r + AW'(1);
      RA_IDXP2:  ra = idx_r + AW'(2);
      RA_IDXM2:  ra = idx_r - AW'(2);
      default:   ra = '0;
    endcase
    unique case (cmd.ix_op)
      IX_HOLD: idx_nxt = idx_r;
      IX_POS:  idx_nxt = pos_r[AW-1:0];
      IX_FILL: idx_nxt = fill_r[AW-1:0];
      IX_ZERO: idx_nxt = '0;
      IX_INC:  idx_nxt = idx_r + AW'(1);
      IX_DEC:  idx_nxt = idx_r - AW'(1);
      default: idx_nxt = idx_r;
    endcase
    fill_nxt = fill_r;
    if (cmd.fill_inc)      fill_nxt = fill_r + CW'(1);
    else if (cmd.fill_dec) fill_nxt = fill_r - CW'(1);
  end

  // One write and one registered read per cycle; a sweep never reads the
  // address it writes in the same cycle.
  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      cap_r       <= CW'(DEPTH);
      out_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (cfg_valid) cap_r <= cfg_capacity_limit;
      if (cmd.out_ld)     out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.req_ld) begin
      func_r   <= in_func;
      pos_r    <= in_position;
      val_r    <= in_value;
      rd_val_r <= '0;
      found_r  <= 1'b0;
      fpos_r   <= '0;
    end
    if (cmd.st_ld)   status_r <= chk;
    if (cmd.rd_cap)  rd_val_r <= rdata_r;
    if (cmd.hit_set) begin
      found_r <= 1'b1;
      fpos_r  <= idx_r;
    end
    if (cmd.out_ld) begin
      out_status         <= status_r;
      out_read_value     <= rd_val_r;
      out_found          <= found_r;
      out_found_position <= fpos_r;
      out_element_count  <= fill_r;
    end
  end

  assign out_valid = out_valid_r;

  assign stat.func       = func_r;
  assign stat.chk        = chk;
  assign stat.ins_at_end = (pos_r == fill_r);
  assign stat.del_last   = ((pos_r + PW'(1)) == fill_r);
  assign stat.dsh_last   = ((CW'(idx_r) + CW'(2)) == fill_r);
  assign stat.ish_last   = (PW'(idx_r) == (pos_r + PW'(1)));
  assign stat.srch_end   = ((CW'(idx_r) + CW'(1)) == fill_r);
  assign stat.hit        = (rdata_r == val_r);
  assign stat.fill_zero  = (fill_r == '0);
  assign stat.out_free   = !out_valid_r || out_ready;

  `SAL_ASSERT_ALWAYS(a_fill_range, fill_r <= CW'(DEPTH), "fill count above depth")
  `SAL_ASSERT_ALWAYS(a_inc_room, !cmd.fill_inc || (fill_r < eff_cap), "growth past limit")
  `SAL_ASSERT_ALWAYS(a_out_free, !cmd.out_ld || !out_valid_r || out_ready, "result overrun")
  `SAL_ASSERT_NEXT(a_out_set, cmd.out_ld, out_valid_r, "result not presented")

endmodule

[hdl/sal_ctrl.sv]
// Controller state machine: sequences decode, memory sweeps and result hand-off.
module sal_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sal_pkg::dp_stat_t stat,
  output sal_pkg::dp_cmd_t  cmd
);
  import sal_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_GETW, S_DELR, S_DSH, S_ISH, S_IFIN, S_SRCH, S_RESP
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.wa_sel   = WA_IDX;
    cmd.ra_sel   = RA_ZERO;
    cmd.ix_op    = IX_HOLD;
    state_nxt    = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.req_ld = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.st_ld = 1'b1;
        state_nxt = S_RESP;
        if (stat.chk == ST_OK) begin
          unique case (stat.func)
            FN_APPEND: begin
              cmd.mem_we   = 1'b1;
              cmd.wa_sel   = WA_FILL;
              cmd.fill_inc = 1'b1;
            end
            FN_EDIT: begin
              cmd.mem_we = 1'b1;
              cmd.wa_sel = WA_POS;
            end
            FN_GET: begin
              cmd.ra_sel = RA_POS;
              state_nxt  = S_GETW;
            end
            FN_DELETE: begin
              cmd.ra_sel = RA_POS;
              state_nxt  = S_DELR;
            end
            FN_INSERT: begin
              if (stat.ins_at_end) begin
                cmd.mem_we   = 1'b1;
                cmd.wa_sel   = WA_POS;
                cmd.fill_inc = 1'b1;
              end else begin
                cmd.ra_sel = RA_FILLM1;
                cmd.ix_op  = IX_FILL;
                state_nxt  = S_ISH;
              end
            end
            FN_SEARCH: begin
              if (!stat.fill_zero) begin
                cmd.ra_sel = RA_ZERO;
                cmd.ix_op  = IX_ZERO;
                state_nxt  = S_SRCH;
              end
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end
      S_GETW: begin
        cmd.rd_cap = 1'b1;
        state_nxt  = S_RESP;
      end
      S_DELR: begin
        cmd.rd_cap = 1'b1;
        if (stat.del_last) begin
          cmd.fill_dec = 1'b1;
          state_nxt    = S_RESP;
        end else begin
          cmd.ra_sel = RA_POS1;
          cmd.ix_op  = IX_POS;
          state_nxt  = S_DSH;
        end
      end
      S_DSH: begin
        cmd.mem_we   = 1'b1;
        cmd.wd_rdata = 1'b1;
        cmd.ra_sel   = RA_IDXP2;
        cmd.ix_op    = IX_INC;
        if (stat.dsh_last) begin
          cmd.fill_dec = 1'b1;
          state_nxt    = S_RESP;
        end
      end
      S_ISH: begin
        cmd.mem_we   = 1'b1;
        cmd.wd_rdata = 1'b1;
        cmd.ra_sel   = RA_IDXM2;
        cmd.ix_op    = IX_DEC;
        if (stat.ish_last) state_nxt = S_IFIN;
      end
      S_IFIN: begin
        cmd.mem_we   = 1'b1;
        cmd.wa_sel   = WA_POS;
        cmd.fill_inc = 1'b1;
        state_nxt    = S_RESP;
      end
      S_SRCH: begin
        priority if (stat.hit) begin
          cmd.hit_set = 1'b1;
          state_nxt   = S_RESP;
        end else if (stat.srch_end) begin
          state_nxt = S_RESP;
        end else begin
          cmd.ra_sel = RA_IDXP1;
          cmd.ix_op  = IX_INC;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hdl/shifting_array_list_table_unit.sv]
// Append, insert at count, edit, no-ops, errors and search on an empty list finish in decode;
// get adds a memory read, delete and inner insert shift the tail, and search walks to a hit
// or the end. A new word is taken only once the last result sits in the output register;
// shifts and search walk the entry memory (one write, one read per cycle), which sets the pace.
// Reset (synchronous, rst_n low): count 0, limit 64, no result pending; the entry
// memory is not cleared, since only written positions are ever used.
module shifting_array_list_table_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration: capacity limit
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sal_pkg::CW-1:0]        cfg_capacity_limit,
  // request words
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sal_pkg::FW-1:0]        in_func,
  input  logic [sal_pkg::PW-1:0]        in_position,
  input  logic signed [sal_pkg::DW-1:0] in_value,
  // result words
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sal_pkg::SW-1:0]        out_status,
  output logic signed [sal_pkg::DW-1:0] out_read_value,
  output logic                          out_found,
  output logic [sal_pkg::AW-1:0]        out_found_position,
  output logic [sal_pkg::CW-1:0]        out_element_count
);
  import sal_pkg::*;

  // Command and status between the sequencer and the datapath.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer: takes a request word only when idle, then walks the memory
  // for insert/delete shifts and searches. The result waits in an output
  // register, so a new word can come in while the last result is pending.
  sal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: entry store, count, limit register, request latch and the
  // output register stage.
  sal_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_capacity_limit (cfg_capacity_limit),
    .in_func            (in_func),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_read_value     (out_read_value),
    .out_found          (out_found),
    .out_found_position (out_found_position),
    .out_element_count  (out_element_count)
  );

endmodule

[tb/list_table_checker.sv]
// Checker for the list table unit: tracks the list, predicts each result word and compares.
`timescale 1ns / 100ps

module list_table_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [sal_pkg::CW-1:0]        cfg_capacity_limit,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [sal_pkg::FW-1:0]        in_func,
  input  logic [sal_pkg::PW-1:0]        in_position,
  input  logic signed [sal_pkg::DW-1:0] in_value,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [sal_pkg::SW-1:0]        out_status,
  input  logic signed [sal_pkg::DW-1:0] out_read_value,
  input  logic                          out_found,
  input  logic [sal_pkg::AW-1:0]        out_found_position,
  input  logic [sal_pkg::CW-1:0]        out_element_count,
  output int                            fail_count,
  output int                            pending,
  output int                            list_len,
  output int                            words_checked,
  output int                            search_hits,
  output int                            full_rejects
);
  import sal_pkg::*;

  typedef struct packed {
    logic [SW-1:0] status;
    logic [DW-1:0] read_value;
    logic          found;
    logic [AW-1:0] found_position;
    logic [CW-1:0] element_count;
  } list_reply_t;

  logic [DW-1:0] cells [DEPTH];
  int unsigned   stored;
  logic [CW-1:0] cap_reg;
  list_reply_t   reply_q [$];
  list_reply_t   oldest;

  initial begin
    fail_count    = 0;
    pending       = 0;
    list_len      = 0;
    words_checked = 0;
    search_hits   = 0;
    full_rejects  = 0;
  end

  // One request against the tracked list; limits above DEPTH act as DEPTH.
  function automatic list_reply_t serve_request(logic [FW-1:0] fn, logic [PW-1:0] pos,
                                                logic [DW-1:0] val);
    list_reply_t r;
    int unsigned lim;
    int unsigned p;
    bit          at_cap;
    r      = '0;
    lim    = (cap_reg > DEPTH) ? DEPTH : cap_reg;
    p      = pos;
    at_cap = (stored >= lim);
    case (fn)
      FN_APPEND: begin
        if (at_cap) begin
          r.status = ST_FULL;
        end else begin
          cells[stored] = val;
          stored++;
        end
      end
      FN_INSERT: begin
        // position check wins over the full check
        if (p > stored) begin
          r.status = ST_BADPOS;
        end else if (at_cap) begin
          r.status = ST_FULL;
        end else begin
          for (int i = stored; i > p; i--) cells[i] = cells[i-1];
          cells[p] = val;
          stored++;
        end
      end
      FN_GET: begin
        if (p >= stored) r.status = ST_BADPOS;
        else r.read_value = cells[p];
      end
      FN_DELETE: begin
        if (p >= stored) begin
          r.status = ST_BADPOS;
        end else begin
          r.read_value = cells[p];
          for (int i = p; i + 1 < stored; i++) cells[i] = cells[i+1];
          stored--;
        end
      end
      FN_EDIT: begin
        if (p >= stored) r.status = ST_BADPOS;
        else cells[p] = val;
      end
      FN_SEARCH: begin
        for (int i = 0; i < stored && !r.found; i++) begin
          if (cells[i] == val) begin
            r.found          = 1'b1;
            r.found_position = AW'(i);
          end
        end
      end
      default: ;
    endcase
    r.element_count = CW'(stored);
    return r;
  endfunction

  task automatic check_field(string name, logic [DW-1:0] want, logic [DW-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      stored  = 0;
      cap_reg = CW'(DEPTH);
      reply_q.delete();
    end else begin
      // a result word always belongs to an earlier request, so check it first
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          $error("result word with no request outstanding");
          fail_count++;
        end else begin
          oldest = reply_q.pop_front();
          check_field("status", DW'(oldest.status), DW'(out_status));
          check_field("read_value", oldest.read_value, out_read_value);
          check_field("found", DW'(oldest.found), DW'(out_found));
          check_field("found_position", DW'(oldest.found_position), DW'(out_found_position));
          check_field("element_count", DW'(oldest.element_count), DW'(out_element_count));
          words_checked++;
          if (oldest.found) search_hits++;
          if (oldest.status == ST_FULL) full_rejects++;
        end
      end
      if (cfg_valid && cfg_ready) cap_reg = cfg_capacity_limit;
      if (in_valid && in_ready) reply_q.push_back(serve_request(in_func, in_position, in_value));
    end
    pending  = reply_q.size();
    list_len = stored;
  end

endmodule

[tb/shifting_array_list_table_unit_tb.sv]
// Top of the list table unit testbench: stimulus, handshake pacing and the final verdict.
`timescale 1ns / 100ps

module shifting_array_list_table_unit_tb;
  import sal_pkg::*;

  // func codes the block treats as no-ops
  localparam logic [FW-1:0] FN_NOP_LO = 3'd6;
  localparam logic [FW-1:0] FN_NOP_HI = 3'd7;

  localparam int BATCH_WORDS = 127;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CW-1:0]        cfg_capacity_limit;
  logic                 in_valid;
  logic                 in_ready;
  logic [FW-1:0]        in_func;
  logic [PW-1:0]        in_position;
  logic signed [DW-1:0] in_value;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [SW-1:0]        out_status;
  logic signed [DW-1:0] out_read_value;
  logic                 out_found;
  logic [AW-1:0]        out_found_position;
  logic [CW-1:0]        out_element_count;

  int fail_count;
  int pending;
  int list_len;
  int words_checked;
  int search_hits;
  int full_rejects;

  // idle odds in percent for the request side and the result side
  int send_idle = 0;
  int recv_idle = 0;
  int words_sent = 0;
  int limits_tried = 0;

  // small pool of values so searches hit and duplicates pile up; extremes included
  logic [DW-1:0] value_pool [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                    32'h7FFF_FFFF, 32'h0000_0007, 32'h0000_1234};

  // per-profile limits: the first entry of each row also hits the corner cases
  logic [CW-1:0] limit_plan [3][4] = '{'{7'd127, 7'd1,  7'd40, 7'd64},
                                       '{7'd0,   7'd64, 7'd17, 7'd2},
                                       '{7'd64,  7'd127, 7'd63, 7'd5}};
  int send_plan [3] = '{35, 63, 0};
  int recv_plan [3] = '{63, 35, 0};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  shifting_array_list_table_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_capacity_limit (cfg_capacity_limit),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_read_value     (out_read_value),
    .out_found          (out_found),
    .out_found_position (out_found_position),
    .out_element_count  (out_element_count)
  );

  list_table_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_capacity_limit (cfg_capacity_limit),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_read_value     (out_read_value),
    .out_found          (out_found),
    .out_found_position (out_found_position),
    .out_element_count  (out_element_count),
    .fail_count         (fail_count),
    .pending            (pending),
    .list_len           (list_len),
    .words_checked      (words_checked),
    .search_hits        (search_hits),
    .full_rejects       (full_rejects)
  );

  // result side: stall at random, one decision per falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Entered and left at a falling edge. Valid stays up across back-to-back words
  // and only drops when the sender decides to idle or a drain begins.
  task automatic send_word(logic [FW-1:0] fn, logic [PW-1:0] pos, logic [DW-1:0] val);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= fn;
    in_position <= pos;
    in_value    <= val;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    words_sent++;
  endtask

  // drop valid, then let every outstanding result come back
  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // only called with the block idle
  task automatic write_limit(logic [CW-1:0] lim);
    drain();
    cfg_valid          <= 1'b1;
    cfg_capacity_limit <= lim;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    limits_tried++;
  endtask

  // growing phases favor append/insert, shrinking phases favor delete
  function automatic logic [FW-1:0] pick_func(bit grow);
    int r;
    r = $urandom_range(0, 99);
    if (grow) begin
      if (r < 40) return FN_APPEND;
      if (r < 75) return FN_INSERT;
      if (r < 82) return FN_GET;
      if (r < 87) return FN_DELETE;
      if (r < 92) return FN_EDIT;
      if (r < 98) return FN_SEARCH;
    end else begin
      if (r < 10) return FN_APPEND;
      if (r < 17) return FN_INSERT;
      if (r < 27) return FN_GET;
      if (r < 72) return FN_DELETE;
      if (r < 82) return FN_EDIT;
      if (r < 98) return FN_SEARCH;
    end
    return $urandom_range(0, 1) ? FN_NOP_LO : FN_NOP_HI;
  endfunction

  // mostly legal positions for the current length, some anywhere, some on the edges
  function automatic logic [PW-1:0] pick_position(logic [FW-1:0] fn);
    int r;
    int top;
    r   = $urandom_range(0, 99);
    top = (fn == FN_INSERT) ? list_len : ((list_len == 0) ? 0 : list_len - 1);
    if (r < 80) return PW'($urandom_range(0, top));
    if (r < 92) return PW'($urandom_range(0, 127));
    case ($urandom_range(0, 3))
      0:       return PW'(list_len);
      1:       return PW'(DEPTH);
      2:       return PW'(DEPTH - 1);
      default: return PW'(127);
    endcase
  endfunction

  function automatic logic [DW-1:0] pick_value;
    if ($urandom_range(0, 99) < 45) return value_pool[$urandom_range(0, 5)];
    return $urandom;
  endfunction

  task automatic run_batch(int n);
    logic [FW-1:0] fn;
    for (int k = 0; k < n; k++) begin
      fn = pick_func(k < (n * 3) / 4);
      send_word(fn, pick_position(fn), pick_value());
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_valid          = 1'b0;
    cfg_capacity_limit = '0;
    in_valid           = 1'b0;
    in_func            = FN_APPEND;
    in_position        = '0;
    in_value           = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty list, then a short list built by every request kind
    send_word(FN_SEARCH, 7'd0, 32'h0000_0005);    // miss on empty list
    send_word(FN_GET,    7'd0, 32'h0);            // nothing stored yet
    send_word(FN_DELETE, 7'd0, 32'h0);
    send_word(FN_EDIT,   7'd0, 32'h1111_1111);
    send_word(FN_INSERT, 7'd1, 32'h2222_2222);    // past the end
    send_word(FN_INSERT, 7'd0, 32'h8000_0000);    // insert at count acts as append
    send_word(FN_APPEND, 7'd0, 32'h7FFF_FFFF);
    send_word(FN_APPEND, 7'd0, 32'hFFFF_FFFF);
    send_word(FN_INSERT, 7'd1, 32'h0000_0000);    // middle insert shifts the tail up
    send_word(FN_INSERT, 7'd4, 32'h5555_5555);
    send_word(FN_APPEND, 7'd0, 32'h7FFF_FFFF);    // duplicate value
    send_word(FN_SEARCH, 7'd0, 32'h7FFF_FFFF);    // lowest match wins
    send_word(FN_GET,    7'd0, 32'h0);
    send_word(FN_GET,    7'd127, 32'h0);
    send_word(FN_EDIT,   7'd3, 32'hAAAA_AAAA);
    send_word(FN_DELETE, 7'd0, 32'h0);            // head removal shifts everything down
    send_word(FN_DELETE, PW'(list_len - 1), 32'h0);
    send_word(FN_SEARCH, 7'd0, 32'h0001_2345);    // absent value
    send_word(FN_NOP_LO, 7'd127, 32'hFFFF_FFFF);
    send_word(FN_NOP_HI, 7'd64, 32'h8000_0000);

    // zero limit: everything is full; bad insert position still reports first
    write_limit(7'd0);
    send_word(FN_APPEND, 7'd0, 32'h0000_0001);
    send_word(FN_INSERT, 7'd127, 32'h0000_0002);
    send_word(FN_INSERT, 7'd0, 32'h0000_0003);
    send_word(FN_GET,    7'd0, 32'h0);
    // limit below the current count: entries stay, removals still work
    write_limit(7'd2);
    send_word(FN_APPEND, 7'd0, 32'h0000_0004);
    send_word(FN_DELETE, 7'd0, 32'h0);

    // random: three pacing mixes, four limits each
    for (int pr = 0; pr < 3; pr++) begin
      drain();
      send_idle = send_plan[pr];
      recv_idle = recv_plan[pr];
      for (int s = 0; s < 4; s++) begin
        write_limit(limit_plan[pr][s]);
        run_batch(BATCH_WORDS);
      end
    end

    drain();
    repeat (80) @(posedge clk);

    $display("Ran %0d request words across %0d limit settings and three pacing mixes.",
             words_sent, limits_tried);
    $display("Checked %0d result words: %0d search hits, %0d overflow rejections.",
             words_checked, search_hits, full_rejects);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
